// ===== hdl/tgc_pkg.sv =====
// shared constants and types of the tap gesture classifier
package tgc_pkg;

    // default geometry and time widths
    localparam int COORD_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 32;

    // fixed widths of the configuration registers
    localparam int RADIUS_W = 12;
    localparam int MSTIME_W = 16;
    localparam int RSQ_W    = 2 * RADIUS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW = 2'd2;

    // configuration reset values
    localparam logic [RADIUS_W-1:0] MOVE_RADIUS_RST   = 12'd10;
    localparam logic [RSQ_W-1:0]    RADIUS_SQ_RST     = 24'd100;
    localparam logic [MSTIME_W-1:0] LONG_TIME_RST     = 16'd500;
    localparam logic [MSTIME_W-1:0] DOUBLE_WINDOW_RST = 16'd300;

    // event kinds
    localparam logic [1:0] ACT_PRESS   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;

    // gesture codes
    localparam logic [1:0] GEST_SINGLE = 2'd0;
    localparam logic [1:0] GEST_DOUBLE = 2'd1;
    localparam logic [1:0] GEST_LONG   = 2'd2;

    // decision handed from the core to the result register
    typedef struct packed {
        logic       emit;
        logic [1:0] gesture;
    } tgc_ctrl_t;

endpackage

// ===== hdl/tgc_core.sv =====
// gesture state and the per-event classification decision
module tgc_core #(
    parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = tgc_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [1:0]                    action,
    input  logic [COORD_BITS-1:0]         pos_x,
    input  logic [COORD_BITS-1:0]         pos_y,
    input  logic [TIME_BITS-1:0]          now_ms,
    input  logic [tgc_pkg::RSQ_W-1:0]     radius_sq,
    input  logic [tgc_pkg::MSTIME_W-1:0]  long_time,
    input  logic [tgc_pkg::MSTIME_W-1:0]  double_window,
    output tgc_pkg::tgc_ctrl_t            ctrl,
    output logic [COORD_BITS-1:0]         res_x,
    output logic [COORD_BITS-1:0]         res_y
);

    localparam int SQ_W  = 2 * COORD_BITS + 1;
    localparam int CMP_W = (SQ_W > tgc_pkg::RSQ_W) ? SQ_W : tgc_pkg::RSQ_W;

    // control state
    logic press_active_reg, press_active_next;
    logic have_last_reg, have_last_next;
    logic pending_reg, pending_next;

    // payload state
    logic [COORD_BITS-1:0] press_x_reg, press_x_next;
    logic [COORD_BITS-1:0] press_y_reg, press_y_next;
    logic [TIME_BITS-1:0]  press_time_reg, press_time_next;
    logic [TIME_BITS-1:0]  last_time_reg, last_time_next;
    logic [COORD_BITS-1:0] pend_x_reg, pend_x_next;
    logic [COORD_BITS-1:0] pend_y_reg, pend_y_next;
    logic [TIME_BITS-1:0]  pend_due_reg, pend_due_next;

    // distance, hold and gap arithmetic
    logic [COORD_BITS-1:0] dx, dy;
    logic [CMP_W-1:0]      dist_sq;
    logic                  in_radius;
    logic [TIME_BITS-1:0]  hold, gap, late;
    logic                  is_long, is_double;

    always_comb
    begin
        dx        = (pos_x > press_x_reg) ? pos_x - press_x_reg : press_x_reg - pos_x;
        dy        = (pos_y > press_y_reg) ? pos_y - press_y_reg : press_y_reg - pos_y;
        dist_sq   = CMP_W'(dx) * CMP_W'(dx) + CMP_W'(dy) * CMP_W'(dy);
        in_radius = dist_sq <= CMP_W'(radius_sq);
        hold      = now_ms - press_time_reg;
        gap       = press_time_reg - last_time_reg;
        late      = now_ms - pend_due_reg;
        is_long   = hold > TIME_BITS'(long_time);
        is_double = have_last_reg && (gap < TIME_BITS'(double_window));
    end

    // event decision
    always_comb
    begin
        press_active_next = press_active_reg;
        have_last_next    = have_last_reg;
        pending_next      = pending_reg;
        press_x_next      = press_x_reg;
        press_y_next      = press_y_reg;
        press_time_next   = press_time_reg;
        last_time_next    = last_time_reg;
        pend_x_next       = pend_x_reg;
        pend_y_next       = pend_y_reg;
        pend_due_next     = pend_due_reg;
        ctrl.emit         = 1'b0;
        ctrl.gesture      = tgc_pkg::GEST_SINGLE;
        res_x             = pos_x;
        res_y             = pos_y;
        unique case (action)
            tgc_pkg::ACT_PRESS:
            begin
                if (!press_active_reg)
                begin
                    press_active_next = 1'b1;
                    press_x_next      = pos_x;
                    press_y_next      = pos_y;
                    press_time_next   = now_ms;
                end
            end
            tgc_pkg::ACT_RELEASE:
            begin
                if (press_active_reg)
                begin
                    press_active_next = 1'b0;
                    if (in_radius)
                    begin
                        last_time_next = press_time_reg;
                        have_last_next = 1'b1;
                        if (is_long)
                        begin
                            ctrl.emit    = 1'b1;
                            ctrl.gesture = tgc_pkg::GEST_LONG;
                        end
                        else if (is_double)
                        begin
                            pending_next = 1'b0;
                            ctrl.emit    = 1'b1;
                            ctrl.gesture = tgc_pkg::GEST_DOUBLE;
                        end
                        else
                        begin
                            pending_next  = 1'b1;
                            pend_x_next   = pos_x;
                            pend_y_next   = pos_y;
                            pend_due_next = now_ms + TIME_BITS'(double_window);
                        end
                    end
                end
            end
            tgc_pkg::ACT_TICK:
            begin
                // pending single is due once now has reached the due time
                if (pending_reg && !late[TIME_BITS-1])
                begin
                    pending_next = 1'b0;
                    ctrl.emit    = 1'b1;
                    ctrl.gesture = tgc_pkg::GEST_SINGLE;
                    res_x        = pend_x_reg;
                    res_y        = pend_y_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_active_reg <= 1'b0;
            have_last_reg    <= 1'b0;
            pending_reg      <= 1'b0;
        end
        else if (fire)
        begin
            press_active_reg <= press_active_next;
            have_last_reg    <= have_last_next;
            pending_reg      <= pending_next;
        end
    end

    // payload state registers
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            press_x_reg    <= press_x_next;
            press_y_reg    <= press_y_next;
            press_time_reg <= press_time_next;
            last_time_reg  <= last_time_next;
            pend_x_reg     <= pend_x_next;
            pend_y_reg     <= pend_y_next;
            pend_due_reg   <= pend_due_next;
        end
    end

endmodule

// ===== hdl/tap_gesture_classifier.sv =====
// top level of the tap gesture classifier
// path: an event passes the input register, then its result is registered in the result register
// throughput: one event per cycle while in_stall is low; the classification is one pass of logic per event
// an event that gives no result never waits; an event whose result
// finds the result register held by out_stall waits in the input register and stalls the input
// reset: rst_n clears the press, last-tap and pending flags and the valid bits, and loads the default configuration
module tap_gesture_classifier #(
    parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = tgc_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      action,
    input  logic [COORD_BITS-1:0]           pos_x,
    input  logic [COORD_BITS-1:0]           pos_y,
    input  logic [TIME_BITS-1:0]            now_ms,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      gesture,
    output logic [COORD_BITS-1:0]           at_x,
    output logic [COORD_BITS-1:0]           at_y,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tgc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [tgc_pkg::RSQ_W-1:0]    radius_sq_reg;
    logic [tgc_pkg::MSTIME_W-1:0] long_time_reg;
    logic [tgc_pkg::MSTIME_W-1:0] window_reg;
    logic [tgc_pkg::RADIUS_W-1:0] radius;

    // input register
    logic                  item_valid_reg, item_valid_next;
    logic [1:0]            item_action_reg;
    logic [COORD_BITS-1:0] item_x_reg, item_y_reg;
    logic [TIME_BITS-1:0]  item_time_reg;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            gesture_reg;
    logic [COORD_BITS-1:0] at_x_reg, at_y_reg;

    tgc_pkg::tgc_ctrl_t    ctrl;
    logic [COORD_BITS-1:0] res_x, res_y;
    logic                  advance, in_xfer, load_out;

    assign cfg_ready = 1'b1;
    assign radius    = cfg_data[tgc_pkg::RADIUS_W-1:0];

    // configuration writes; the radius is kept squared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq_reg <= tgc_pkg::RADIUS_SQ_RST;
            long_time_reg <= tgc_pkg::LONG_TIME_RST;
            window_reg    <= tgc_pkg::DOUBLE_WINDOW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tgc_pkg::CFG_MOVE_RADIUS:
                    radius_sq_reg <= tgc_pkg::RSQ_W'(radius) * tgc_pkg::RSQ_W'(radius);
                tgc_pkg::CFG_LONG_TIME:     long_time_reg <= cfg_data;
                tgc_pkg::CFG_DOUBLE_WINDOW: window_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tgc_core #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .action        (item_action_reg),
        .pos_x         (item_x_reg),
        .pos_y         (item_y_reg),
        .now_ms        (item_time_reg),
        .radius_sq     (radius_sq_reg),
        .long_time     (long_time_reg),
        .double_window (window_reg),
        .ctrl          (ctrl),
        .res_x         (res_x),
        .res_y         (res_y)
    );

    // the held event moves on unless its result finds the result register blocked
    always_comb
    begin
        advance         = item_valid_reg && (!ctrl.emit || !out_valid_reg || !out_stall);
        in_stall        = item_valid_reg && !advance;
        in_xfer         = in_valid && !in_stall;
        load_out        = advance && ctrl.emit;
        item_valid_next = in_xfer ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
        out_valid_next  = load_out ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // input transfer capture
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_action_reg <= action;
            item_x_reg      <= pos_x;
            item_y_reg      <= pos_y;
            item_time_reg   <= now_ms;
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            gesture_reg <= ctrl.gesture;
            at_x_reg    <= res_x;
            at_y_reg    <= res_y;
        end
    end

    assign out_valid = out_valid_reg;
    assign gesture   = gesture_reg;
    assign at_x      = at_x_reg;
    assign at_y      = at_y_reg;

endmodule

// ===== tb/tap_gesture_classifier_test.sv =====
// testbench of the tap gesture classifier: queued stimulus, clocked driver and monitor, predictor
module tap_gesture_classifier_test;

    timeunit 1ns;
    timeprecision 1ps;

    // unused event code, must be ignored by the block
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] x;
        logic [11:0] y;
        logic [31:0] t;
    } tap_event_t;

    typedef struct packed {
        logic [1:0]  gesture;
        logic [11:0] x;
        logic [11:0] y;
    } gesture_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = 2'd0;
    logic [11:0] pos_x = '0;
    logic [11:0] pos_y = '0;
    logic [31:0] now_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  gesture;
    logic [11:0] at_x;
    logic [11:0] at_y;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [tgc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tgc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    tap_gesture_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .now_ms    (now_ms),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .gesture   (gesture),
        .at_x      (at_x),
        .at_y      (at_y),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // pending events and expected gestures
    tap_event_t event_q[$];
    gesture_t   gesture_q[$];
    tap_event_t cur_event;
    int         errors = 0;
    int         send_gap = 0;
    int         stall_left = 0;
    int         cycle_count = 0;
    bit         calm = 1'b0;
    logic [31:0] clock_ms = '0;

    // predictor copy of the configuration
    logic [11:0] cfg_radius = tgc_pkg::MOVE_RADIUS_RST;
    logic [15:0] cfg_long   = tgc_pkg::LONG_TIME_RST;
    logic [15:0] cfg_window = tgc_pkg::DOUBLE_WINDOW_RST;

    // predictor copy of the classifier state
    bit          pr_active = 1'b0;
    logic [11:0] pr_x = '0;
    logic [11:0] pr_y = '0;
    logic [31:0] pr_time = '0;
    logic [31:0] last_tap_time = '0;
    bit          have_last_tap = 1'b0;
    bit          single_armed = 1'b0;
    logic [11:0] armed_x = '0;
    logic [11:0] armed_y = '0;
    logic [31:0] armed_due = '0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        errors++;
    endtask

    function automatic gesture_t make_gesture(input logic [1:0] g, input logic [11:0] x,
                                              input logic [11:0] y);
        gesture_t r;
        r.gesture = g;
        r.x = x;
        r.y = y;
        return r;
    endfunction

    // add one gesture at the tail of the expected queue
    task automatic expect_gesture(input logic [1:0] g, input logic [11:0] x,
                                  input logic [11:0] y);
        gesture_q.insert(gesture_q.size(), make_gesture(g, x, y));
    endtask

    // advance the predicted state by one accepted event
    task automatic classify_event(input tap_event_t ev);
        logic [31:0] dx, dy, dist_sq, rad_sq, hold, gap, late;
        if (ev.action == tgc_pkg::ACT_PRESS)
        begin
            if (!pr_active)
            begin
                pr_x = ev.x;
                pr_y = ev.y;
                pr_time = ev.t;
                pr_active = 1'b1;
            end
        end
        else if (ev.action == tgc_pkg::ACT_RELEASE)
        begin
            if (pr_active)
            begin
                pr_active = 1'b0;
                dx = (ev.x > pr_x) ? 32'(ev.x - pr_x) : 32'(pr_x - ev.x);
                dy = (ev.y > pr_y) ? 32'(ev.y - pr_y) : 32'(pr_y - ev.y);
                dist_sq = dx * dx + dy * dy;
                rad_sq = 32'(cfg_radius) * 32'(cfg_radius);
                if (dist_sq <= rad_sq)
                begin
                    hold = ev.t - pr_time;
                    gap = pr_time - last_tap_time;
                    if (hold > 32'(cfg_long))
                    begin
                        expect_gesture(tgc_pkg::GEST_LONG, ev.x, ev.y);
                    end
                    else if (have_last_tap && gap < 32'(cfg_window))
                    begin
                        single_armed = 1'b0;
                        expect_gesture(tgc_pkg::GEST_DOUBLE, ev.x, ev.y);
                    end
                    else
                    begin
                        single_armed = 1'b1;
                        armed_x = ev.x;
                        armed_y = ev.y;
                        armed_due = ev.t + 32'(cfg_window);
                    end
                    last_tap_time = pr_time;
                    have_last_tap = 1'b1;
                end
            end
        end
        else if (ev.action == tgc_pkg::ACT_TICK && single_armed)
        begin
            late = ev.t - armed_due;
            if (!late[31])
            begin
                single_armed = 1'b0;
                expect_gesture(tgc_pkg::GEST_SINGLE, armed_x, armed_y);
            end
        end
    endtask

    task automatic push_event(input logic [1:0] act, input logic [11:0] x, input logic [11:0] y,
                              input logic [31:0] t);
        tap_event_t ev;
        ev.action = act;
        ev.x = x;
        ev.y = y;
        ev.t = t;
        event_q.insert(event_q.size(), ev);
    endtask

    // input driver: one event per transfer, random idle bursts unless calm is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                classify_event(cur_event);
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0 && !calm)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (event_q.size() > 0)
                begin
                    if (!calm && $urandom_range(0, 9) == 0)
                    begin
                        send_gap = $urandom_range(0, 16);
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        cur_event = event_q.pop_front();
                        in_valid <= 1'b1;
                        action <= cur_event.action;
                        pos_x <= cur_event.x;
                        pos_y <= cur_event.y;
                        now_ms <= cur_event.t;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0 && !calm)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // monitor: compare each result transfer with the oldest expected gesture
    always @(posedge clk)
    begin : monitor
        gesture_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (gesture_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected gesture %0d at (%0d,%0d)",
                                          gesture, at_x, at_y));
            end
            else
            begin
                want = gesture_q.pop_front();
                if (gesture !== want.gesture)
                    report_mismatch($sformatf("gesture %0d, expected %0d", gesture, want.gesture));
                if (at_x !== want.x)
                    report_mismatch($sformatf("at_x %0d, expected %0d", at_x, want.x));
                if (at_y !== want.y)
                    report_mismatch($sformatf("at_y %0d, expected %0d", at_y, want.y));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [tgc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tgc_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == tgc_pkg::CFG_MOVE_RADIUS)
            cfg_radius = data[11:0];
        else if (idx == tgc_pkg::CFG_LONG_TIME)
            cfg_long = data;
        else if (idx == tgc_pkg::CFG_DOUBLE_WINDOW)
            cfg_window = data;
    endtask

    // wait until every event is sent and every gesture has arrived
    task automatic wait_idle();
        while (event_q.size() != 0 || in_valid || gesture_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [11:0] nudge(input logic [11:0] c);
        int d, v;
        if ($urandom_range(0, 1))
            d = $urandom_range(0, int'(cfg_radius) / 2 + 1);
        else
            d = $urandom_range(0, int'(cfg_radius) + 2);
        v = $urandom_range(0, 1) ? int'(c) + d : int'(c) - d;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    function automatic logic [31:0] hold_span();
        case ($urandom_range(0, 2))
            0: return $urandom_range(0, int'(cfg_long));
            1: return 32'(cfg_long) + $urandom_range(0, 1);
            default: return $urandom_range(0, 2 * int'(cfg_long) + 4);
        endcase
    endfunction

    function automatic logic [31:0] window_span();
        if ($urandom_range(0, 3) == 0)
            return 32'(cfg_window) + $urandom_range(0, 1) - 1;
        return $urandom_range(0, 2 * int'(cfg_window) + 4);
    endfunction

    // random taps: mostly well-formed press/release pairs and ticks, some noise
    task automatic add_gestures(input int target);
        int made, kind;
        logic [11:0] px, py;
        made = 0;
        while (made < target)
        begin
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0)
                clock_ms = $urandom();
            if (kind < 70)
            begin
                px = 12'($urandom());
                py = 12'($urandom());
                push_event(tgc_pkg::ACT_PRESS, px, py, clock_ms);
                if ($urandom_range(0, 9) == 0)
                    push_event(tgc_pkg::ACT_PRESS, 12'($urandom()), 12'($urandom()),
                               clock_ms + $urandom_range(0, 3));
                clock_ms += hold_span();
                if ($urandom_range(0, 3) == 0)
                    push_event(tgc_pkg::ACT_TICK, 12'($urandom()), 12'($urandom()), clock_ms);
                if ($urandom_range(0, 19) != 0)
                    push_event(tgc_pkg::ACT_RELEASE, nudge(px), nudge(py), clock_ms);
                made += 2;
                if ($urandom_range(0, 1))
                    clock_ms += window_span();
            end
            else if (kind < 90)
            begin
                clock_ms += window_span();
                push_event(tgc_pkg::ACT_TICK, 12'($urandom()), 12'($urandom()), clock_ms);
                made++;
            end
            else
            begin
                push_event(2'($urandom_range(0, 3)), 12'($urandom()), 12'($urandom()),
                           $urandom());
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: default configuration (radius 10, long 500, window 300)
        push_event(ACT_NONE, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
        push_event(tgc_pkg::ACT_RELEASE, 12'd5, 12'd5, 32'd100);       // release with no press
        push_event(tgc_pkg::ACT_PRESS, 12'd0, 12'd0, 32'hFFFF_FF00);
        push_event(tgc_pkg::ACT_PRESS, 12'd4095, 12'd4095, 32'hFFFF_FF08); // ignored second press
        push_event(tgc_pkg::ACT_RELEASE, 12'd6, 12'd8, 32'h0000_0010); // on the radius, first tap
        push_event(tgc_pkg::ACT_TICK, 12'd0, 12'd0, 32'h0000_013B);    // one short of due
        push_event(tgc_pkg::ACT_PRESS, 12'd4095, 12'd4095, 32'h0000_0020);
        push_event(tgc_pkg::ACT_RELEASE, 12'd4095, 12'd4095, 32'h0000_0030); // double across wrap
        push_event(tgc_pkg::ACT_TICK, 12'd0, 12'd0, 32'h0000_0200);    // single was canceled
        push_event(tgc_pkg::ACT_PRESS, 12'd100, 12'd100, 32'd1000);
        push_event(tgc_pkg::ACT_RELEASE, 12'd100, 12'd100, 32'd1050);
        push_event(tgc_pkg::ACT_PRESS, 12'd2048, 12'd1024, 32'd1400);
        push_event(tgc_pkg::ACT_RELEASE, 12'd2048, 12'd1024, 32'd1410); // replaces pending single
        push_event(tgc_pkg::ACT_TICK, 12'd0, 12'd0, 32'd1709);
        push_event(tgc_pkg::ACT_TICK, 12'd0, 12'd0, 32'd1710);
        push_event(tgc_pkg::ACT_TICK, 12'd0, 12'd0, 32'd1800);
        push_event(tgc_pkg::ACT_PRESS, 12'd500, 12'd500, 32'd3000);
        push_event(tgc_pkg::ACT_RELEASE, 12'd507, 12'd508, 32'd3010);  // moved too far
        push_event(tgc_pkg::ACT_PRESS, 12'd300, 12'd300, 32'd4000);
        push_event(tgc_pkg::ACT_RELEASE, 12'd300, 12'd300, 32'd4501);  // long
        push_event(tgc_pkg::ACT_PRESS, 12'd300, 12'd300, 32'd5000);
        push_event(tgc_pkg::ACT_RELEASE, 12'd300, 12'd300, 32'd5500);  // hold at the limit
        push_event(tgc_pkg::ACT_PRESS, 12'd1, 12'd1, 32'd5100);
        push_event(tgc_pkg::ACT_RELEASE, 12'd1, 12'd1, 32'd5700);      // long keeps the single
        push_event(tgc_pkg::ACT_TICK, 12'd0, 12'd0, 32'd5800);
        wait_idle();

        // smallest settings
        write_reg(tgc_pkg::CFG_MOVE_RADIUS, 16'h0000);
        write_reg(tgc_pkg::CFG_LONG_TIME, 16'h0000);
        write_reg(tgc_pkg::CFG_DOUBLE_WINDOW, 16'h0000);
        add_gestures(100);
        wait_idle();

        // largest settings, upper data bits set on the radius write
        write_reg(tgc_pkg::CFG_MOVE_RADIUS, 16'hFFFF);
        write_reg(tgc_pkg::CFG_LONG_TIME, 16'hFFFF);
        write_reg(tgc_pkg::CFG_DOUBLE_WINDOW, 16'hFFFF);
        add_gestures(100);
        wait_idle();

        // random moderate settings and a write to the unused index
        write_reg(ACT_NONE, 16'($urandom()));
        write_reg(tgc_pkg::CFG_MOVE_RADIUS, {4'($urandom()), 12'($urandom_range(0, 40))});
        write_reg(tgc_pkg::CFG_LONG_TIME, 16'($urandom_range(0, 2000)));
        write_reg(tgc_pkg::CFG_DOUBLE_WINDOW, 16'($urandom_range(0, 1500)));
        add_gestures(220);
        wait_idle();

        // back to typical settings, no idling on either side
        calm = 1'b1;
        write_reg(tgc_pkg::CFG_MOVE_RADIUS, 16'd10);
        write_reg(tgc_pkg::CFG_LONG_TIME, 16'd500);
        write_reg(tgc_pkg::CFG_DOUBLE_WINDOW, 16'd300);
        add_gestures(220);
        wait_idle();

        if (errors == 0 && gesture_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== tap_gesture_classifier.f =====
hdl/tgc_pkg.sv
hdl/tgc_core.sv
hdl/tap_gesture_classifier.sv
tb/tap_gesture_classifier_test.sv
